// ===== hdl/fifo_queue_with_key_search_core_defines.svh =====
// ----------------------------------------------------------------------------
// fifo queue with key search - assertion macros
// shared concurrent assertion forms used at the top level
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_KEY_SEARCH_CORE_DEFINES_SVH
`define FIFO_QUEUE_WITH_KEY_SEARCH_CORE_DEFINES_SVH

// same-cycle implication
`define FQKS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fqks assertion failed");

// next-cycle implication
`define FQKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fqks assertion failed");

`endif

// ===== hdl/fqks_pkg.sv =====
// ----------------------------------------------------------------------------
// fqks_pkg
// types, sizes and opcodes shared by the fifo queue with key search
// ----------------------------------------------------------------------------
package fqks_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 5;
   localparam int KEY_W = 32;
   localparam int COND_W = 8;
   localparam int TIME_W = 32;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_FIND    = 2'd2;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [KEY_W-1:0]  key_id;
      logic [COND_W-1:0] condition_code;
      logic [TIME_W-1:0] admission_time;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic             found;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] length;
      logic             empty_res;
      logic [KEY_W-1:0] head_key;
      logic [KEY_W-1:0] tail_key;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan_step;
      logic stat_rd;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic is_find;
      logic scan_done;
      logic out_free;
   } stat_type;

endpackage

// ===== hdl/fqks_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqks_ctrl
// sequencer for one operation: execute, optional key scan, status read, load
// ----------------------------------------------------------------------------
module fqks_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fqks_pkg::stat_type stat,
   output fqks_pkg::cmd_type  cmd
);
   import fqks_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_STAT,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.is_find ? ST_SCAN : ST_STAT;
         end
         ST_SCAN: begin
            if (stat.scan_done) state_in = ST_STAT;
         end
         ST_STAT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.capture   = accept;
      cmd.exec      = (state_ff == ST_EXEC);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.stat_rd   = (state_ff == ST_STAT);
      cmd.load      = (state_ff == ST_DONE) && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/fqks_datapath.sv =====
// ----------------------------------------------------------------------------
// fqks_datapath
// record ring memories, pointers, key scan compare and result register
// ----------------------------------------------------------------------------
module fqks_datapath (
   input  logic               clock,
   input  logic               reset,
   input  fqks_pkg::req_type  req_data,
   input  fqks_pkg::cmd_type  cmd,
   output fqks_pkg::stat_type stat,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output fqks_pkg::rsp_type  rsp_data
);
   import fqks_pkg::*;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

   logic [KEY_W-1:0]  key_mem  [DEPTH];
   logic [COND_W-1:0] cond_mem [DEPTH];
   logic [TIME_W-1:0] time_mem [DEPTH];

   req_type           req_ff;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]  scan_num_ff, scan_num_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              ok_ff, ok_in;
   logic              found_ff, found_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [KEY_W-1:0]  rd_a_ff;
   logic [KEY_W-1:0]  rd_b_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              full;
   logic              empty;
   logic              wr_en;
   logic              hit;
   logic              issue;
   logic              rd_en_a;
   logic [IDX_W-1:0]  rd_addr_a;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign wr_en = cmd.exec && (req_ff.opcode == OP_ENQUEUE) && !full;
   assign hit   = cmp_vld_ff && (rd_a_ff == req_ff.key_id);
   assign issue = cmd.scan_step && !hit && (scan_num_ff != count_ff);

   assign rd_en_a   = cmd.stat_rd || issue;
   assign rd_addr_a = cmd.stat_rd ? head_ff : scan_idx_ff;

   assign stat.is_find   = (req_ff.opcode == OP_FIND);
   assign stat.scan_done = hit || (scan_num_ff == count_ff);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      scan_num_in = scan_num_ff;
      cmp_vld_in  = 1'b0;
      ok_in       = ok_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;

      if (cmd.exec) begin
         ok_in       = 1'b0;
         found_in    = 1'b0;
         pos_in      = '0;
         scan_idx_in = head_ff;
         scan_num_in = '0;
         case (req_ff.opcode)
            OP_ENQUEUE: begin
               if (!full) begin
                  tail_in  = ring_next(tail_ff);
                  count_in = count_ff + 1'b1;
                  ok_in    = 1'b1;
               end
            end
            OP_DEQUEUE: begin
               if (!empty) begin
                  head_in  = ring_next(head_ff);
                  count_in = count_ff - 1'b1;
                  ok_in    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_step && hit) begin
         ok_in    = 1'b1;
         found_in = 1'b1;
         pos_in   = scan_num_ff;
      end

      if (issue) begin
         scan_idx_in = ring_next(scan_idx_ff);
         scan_num_in = scan_num_ff + 1'b1;
         cmp_vld_in  = 1'b1;
      end
   end

   always_comb begin
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.ok          = ok_ff;
         rsp_in.found       = found_ff;
         rsp_in.position    = POS_W'(pos_ff);
         rsp_in.length      = POS_W'(count_ff);
         rsp_in.empty_res   = empty;
         rsp_in.head_key    = empty ? '0 : rd_a_ff;
         rsp_in.tail_key    = empty ? '0 : rd_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      scan_idx_ff <= scan_idx_in;
      scan_num_ff <= scan_num_in;
      ok_ff       <= ok_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      rsp_ff      <= rsp_in;
   end

   // record ring: one write port, two registered key read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[tail_ff]  <= req_ff.key_id;
         cond_mem[tail_ff] <= req_ff.condition_code;
         time_mem[tail_ff] <= req_ff.admission_time;
      end
      if (rd_en_a) rd_a_ff <= key_mem[rd_addr_a];
      if (cmd.stat_rd) rd_b_ff <= key_mem[ring_prev(tail_ff)];
   end

endmodule

// ===== hdl/fifo_queue_with_key_search_core.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_key_search_core
// bounded record queue with enqueue, dequeue and find-by-key operations
// ----------------------------------------------------------------------------
// One request beat is taken at a time and yields one response beat. Enqueue,
// dequeue and the unused opcode step from accept through execute, a status
// read of the head and rear keys, and the load of the response register,
// which waits until the output register is free. A find adds a scan of the
// key memory from the head, one record per cycle through its single scan read
// port, plus a last compare; the scan ends early when the key is hit. A new
// request is taken while an earlier response still waits in the output
// register; its result is held until that response is taken.
module fifo_queue_with_key_search_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fqks_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fqks_pkg::rsp_type rsp_data
);
   import fqks_pkg::*;

`include "fifo_queue_with_key_search_core_defines.svh"

   cmd_type  cmd;
   stat_type stat;

   fqks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fqks_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // busy after every accepted beat
   `FQKS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // empty response reports zero length and zero keys
   `FQKS_ASSERT_NOW(a_empty_status, clock, reset, rsp_valid && rsp_data.empty_res, (rsp_data.length == '0) && (rsp_data.head_key == '0) && (rsp_data.tail_key == '0))

   // found key lies inside the queue
   `FQKS_ASSERT_NOW(a_found_position, clock, reset, rsp_valid && rsp_data.found, rsp_data.ok && (rsp_data.position != '0) && (rsp_data.position <= rsp_data.length))

endmodule
